// File: rtl/cvs_pkg.sv
// Shared constants and types for the coin value selector.
`timescale 1ns / 1ps

package cvs_pkg;

   localparam int MAX_POINTS  = 32;
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int AMT_W       = 64;
   localparam int PIDX_W      = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MINIMUM = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SELECT_MODE    = CSR_IDX_W'(1);

   // What the back end does with a queued item
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_LOAD_LAST,
      KIND_RUN_ONLY
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [AMT_W-1:0]       amount;
   } entry_type;

   typedef struct packed {
      logic [AMT_W-1:0]       target_minimum;
      logic                   select_mode;
   } cfg_type;

endpackage

// File: rtl/cvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cvs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cvs_front.sv
// Input front end: accepts points and tags each one for the back end.
`timescale 1ns / 1ps

module cvs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [63:0]         req_point_amount,
   input  logic                req_final_point,
   output logic                push_valid,
   input  logic                push_ready,
   output cvs_pkg::entry_type  push_entry
);

   localparam int CNT_W = cvs_pkg::CNT_W;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             has_room;
   logic             accept;

   always_comb begin
      has_room = count_ff < CNT_W'(cvs_pkg::MAX_POINTS);
      req_ready = push_ready;
      accept = req_valid && req_ready;
      // a non-final point that finds the store full is dropped here
      push_valid = req_valid && push_ready && (has_room || req_final_point);
      push_entry.amount = req_point_amount;
      if (!has_room) begin
         push_entry.kind = cvs_pkg::KIND_RUN_ONLY;
      end else if (req_final_point) begin
         push_entry.kind = cvs_pkg::KIND_LOAD_LAST;
      end else begin
         push_entry.kind = cvs_pkg::KIND_LOAD;
      end
      count_in = count_ff;
      if (accept) begin
         if (req_final_point) begin
            count_in = '0;
         end else if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/cvs_queue.sv
// Short FIFO between the front end and the selection engine.
`timescale 1ns / 1ps

module cvs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  cvs_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output cvs_pkg::entry_type  pop_entry
);

   localparam int DEPTH   = cvs_pkg::QUEUE_DEPTH;
   localparam int QPTR_W  = cvs_pkg::QPTR_W;
   localparam int QFILL_W = cvs_pkg::QFILL_W;

   cvs_pkg::entry_type slot_ff [DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               push;
   logic               pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      push_ready = fill_ff != QFILL_W'(DEPTH);
      pop_valid  = fill_ff != '0;
      pop_entry  = slot_ff[rd_ptr_ff];
      push = push_valid && push_ready;
      pop  = pop_valid && pop_ready;
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: rtl/cvs_back.sv
// Selection engine: loads the point store, scans it and emits the selection.
`timescale 1ns / 1ps

module cvs_back (
   input  logic                clock,
   input  logic                reset,
   input  cvs_pkg::cfg_type    cfg,
   input  logic                q_valid,
   output logic                q_ready,
   input  cvs_pkg::entry_type  q_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic [4:0]          rsp_point_index,
   output logic [63:0]         rsp_chosen_amount,
   output logic                rsp_run_end
);

   localparam int MAX_POINTS = cvs_pkg::MAX_POINTS;
   localparam int IDX_W      = cvs_pkg::IDX_W;
   localparam int CNT_W      = cvs_pkg::CNT_W;
   localparam int AMT_W      = cvs_pkg::AMT_W;
   localparam int PIDX_W     = cvs_pkg::PIDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_DRAIN,
      ST_RESOLVE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      PH_REACH_ONE,
      PH_LARGEST,
      PH_REACH_ALL
   } phase_type;

   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [AMT_W-1:0]  total_ff, total_in;
   logic [AMT_W-1:0]  sum_ff, sum_in;
   logic [MAX_POINTS-1:0] taken_ff, taken_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [AMT_W-1:0]  best_amt_ff, best_amt_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [AMT_W-1:0]  pend_amt_ff, pend_amt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [PIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [AMT_W-1:0]  rsp_amount_ff, rsp_amount_in;
   logic              rsp_run_end_ff, rsp_run_end_in;

   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [AMT_W-1:0]  ram_rd_data;
   logic              out_free;
   logic              do_load;
   logic              do_run;
   logic              cand_ok;
   logic              cand_better;
   logic              scan_last;
   logic [AMT_W-1:0]  new_sum;

   function automatic logic [AMT_W-1:0] sat_add(input logic [AMT_W-1:0] a,
                                                input logic [AMT_W-1:0] b);
      logic [AMT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[AMT_W] ? '1 : s[AMT_W-1:0];
   endfunction

   cvs_ram #(
      .WIDTH (AMT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (q_entry.amount),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      sum_in         = sum_ff;
      taken_in       = taken_ff;
      scan_idx_in    = scan_idx_ff;
      rd_pend_in     = 1'b0;
      rd_idx_in      = rd_idx_ff;
      best_valid_in  = best_valid_ff;
      best_idx_in    = best_idx_ff;
      best_amt_in    = best_amt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      pend_amt_in    = pend_amt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_found_in   = rsp_found_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_amount_in  = rsp_amount_ff;
      rsp_run_end_in = rsp_run_end_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      out_free  = !rsp_valid_ff || rsp_ready;
      q_ready   = state_ff == ST_IDLE;
      do_load   = q_valid && q_ready && (q_entry.kind == cvs_pkg::KIND_LOAD ||
                                         q_entry.kind == cvs_pkg::KIND_LOAD_LAST);
      do_run    = q_valid && q_ready && (q_entry.kind == cvs_pkg::KIND_LOAD_LAST ||
                                         q_entry.kind == cvs_pkg::KIND_RUN_ONLY);
      scan_last = CNT_W'(scan_idx_ff) == count_ff - CNT_W'(1);
      new_sum   = sat_add(sum_ff, best_amt_ff);

      // compare the entry read last cycle against the best so far
      cand_ok = !taken_ff[rd_idx_ff] &&
                (phase_ff == PH_LARGEST || ram_rd_data >= cfg.target_minimum);
      cand_better = !best_valid_ff ||
                    ((phase_ff == PH_LARGEST) ? (ram_rd_data > best_amt_ff)
                                              : (ram_rd_data < best_amt_ff));
      if (rd_pend_ff && cand_ok && cand_better) begin
         best_valid_in = 1'b1;
         best_idx_in   = rd_idx_ff;
         best_amt_in   = ram_rd_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (do_load) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               total_in  = sat_add(total_ff, q_entry.amount);
            end
            if (do_run) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (count_ff == '0 ||
                (!cfg.select_mode && total_ff < cfg.target_minimum)) begin
               state_in = ST_FINISH;
            end else begin
               phase_in      = cfg.select_mode ? PH_REACH_ALL : PH_REACH_ONE;
               state_in      = ST_SCAN;
               scan_idx_in   = '0;
               best_valid_in = 1'b0;
            end
         end
         ST_SCAN: begin
            ram_rd_en  = 1'b1;
            rd_pend_in = 1'b1;
            rd_idx_in  = scan_idx_ff;
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            priority if (!best_valid_ff) begin
               if (phase_ff == PH_REACH_ONE) begin
                  // no single point reaches: take largest first
                  phase_in      = PH_LARGEST;
                  state_in      = ST_SCAN;
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (phase_ff == PH_REACH_ONE) begin
               pend_valid_in = 1'b1;
               pend_idx_in   = best_idx_ff;
               pend_amt_in   = best_amt_ff;
               state_in      = ST_FINISH;
            end else if (!pend_valid_ff || out_free) begin
               // release the previous pick; the new one waits to learn if it ends the run
               if (pend_valid_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_found_in   = 1'b1;
                  rsp_index_in   = PIDX_W'(pend_idx_ff);
                  rsp_amount_in  = pend_amt_ff;
                  rsp_run_end_in = 1'b0;
               end
               pend_valid_in         = 1'b1;
               pend_idx_in           = best_idx_ff;
               pend_amt_in           = best_amt_ff;
               taken_in[best_idx_ff] = 1'b1;
               if (phase_ff == PH_LARGEST && new_sum >= cfg.target_minimum) begin
                  sum_in   = new_sum;
                  state_in = ST_FINISH;
               end else begin
                  sum_in        = (phase_ff == PH_LARGEST) ? new_sum : sum_ff;
                  state_in      = ST_SCAN;
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = pend_valid_ff;
               rsp_index_in   = pend_valid_ff ? PIDX_W'(pend_idx_ff) : '0;
               rsp_amount_in  = pend_valid_ff ? pend_amt_ff : '0;
               rsp_run_end_in = 1'b1;
               count_in       = '0;
               total_in       = '0;
               sum_in         = '0;
               taken_in       = '0;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_REACH_ONE;
         count_ff      <= '0;
         total_ff      <= '0;
         sum_ff        <= '0;
         taken_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         total_ff       <= total_in;
         sum_ff         <= sum_in;
         taken_ff       <= taken_in;
         scan_idx_ff    <= scan_idx_in;
         rd_pend_ff     <= rd_pend_in;
         rd_idx_ff      <= rd_idx_in;
         best_valid_ff  <= best_valid_in;
         best_idx_ff    <= best_idx_in;
         best_amt_ff    <= best_amt_in;
         pend_valid_ff  <= pend_valid_in;
         pend_idx_ff    <= pend_idx_in;
         pend_amt_ff    <= pend_amt_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_found_ff   <= rsp_found_in;
         rsp_index_ff   <= rsp_index_in;
         rsp_amount_ff  <= rsp_amount_in;
         rsp_run_end_ff <= rsp_run_end_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_point_index   = rsp_index_ff;
   assign rsp_chosen_amount = rsp_amount_ff;
   assign rsp_run_end       = rsp_run_end_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count exceeds store depth");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && out_free |=> count_ff == '0 && total_ff == '0)
      else $error("selection end did not clear the loaded set");

   a_idle_marks_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> taken_ff == '0)
      else $error("taken marks left set outside a selection run");

   a_empty_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_run_end_ff)
      else $error("empty selection result not marked as run end");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == ST_SCAN || state_ff == ST_DRAIN)
      else $error("store read outstanding outside a scan");

endmodule

// File: rtl/coin_value_selector.sv
// Top level of the coin value selector: registers, front end, queue and engine.
`timescale 1ns / 1ps
//
//  Port group   Direction   Meaning
//  req_*        in          one point per transfer; final_point starts selection
//  rsp_*        out         one selected point per transfer; run_end marks the last
//  csr_*        in          register writes: target minimum, select mode
//
//  Points that are not final go to the store RAM while the engine is idle, not during a run.
//  A final point starts the selection, which scans the loaded points in passes
//  (greedy: none if the total falls short, one pass if a single point reaches, else
//  one plus one per value taken; individual: one per qualifying point plus one),
//  and then closes the run.
//  Reset is synchronous and clears counts, totals and marks; the store is not swept.
//  rsp_ready low holds the engine at its next result; the 2-entry queue keeps
//  req_ready high until it fills while a run is under way.

module coin_value_selector (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_point_amount,
   input  logic        req_final_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [4:0]  rsp_point_index,
   output logic [63:0] rsp_chosen_amount,
   output logic        rsp_run_end,
   input  logic        csr_wr_en,
   input  logic [cvs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0] csr_wr_data
);

   logic [63:0]        target_ff;
   logic               mode_ff;
   cvs_pkg::cfg_type   cfg;
   logic               push_valid;
   logic               push_ready;
   cvs_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop_ready;
   cvs_pkg::entry_type pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         mode_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cvs_pkg::CSR_TARGET_MINIMUM: target_ff <= csr_wr_data;
            cvs_pkg::CSR_SELECT_MODE:    mode_ff   <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.target_minimum = target_ff;
   assign cfg.select_mode    = mode_ff;

   cvs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_point_amount (req_point_amount),
      .req_final_point  (req_final_point),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   cvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   cvs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (pop_valid),
      .q_ready           (pop_ready),
      .q_entry           (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_point_index   (rsp_point_index),
      .rsp_chosen_amount (rsp_chosen_amount),
      .rsp_run_end       (rsp_run_end)
   );

endmodule

// File: tb/sv/tb_coin_value_selector.sv
// Testbench for the coin value selector: predicted selections checked per transfer.
`timescale 1ns / 1ps

module tb_coin_value_selector;

   localparam logic [63:0] ALL_ONES    = {64{1'b1}};
   localparam int          POINT_GOAL  = 340;
   localparam int          SETTLE_CYC  = 40;

   typedef struct packed {
      logic        found;
      logic [4:0]  index;
      logic [63:0] amount;
      logic        run_end;
   } pick_type;

   class selection_checker;
      logic [63:0] amounts [cvs_pkg::MAX_POINTS];
      bit          taken [cvs_pkg::MAX_POINTS];
      int          loaded;
      logic [63:0] total;
      logic [63:0] target;
      logic        mode;
      pick_type    run_picks [$];
      pick_type    expected_picks [$];
      int          errors;
      int          checked;

      function new();
         loaded  = 0;
         total   = '0;
         target  = '0;
         mode    = 1'b0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_register(logic [cvs_pkg::CSR_IDX_W-1:0] index, logic [63:0] data);
         if (index == cvs_pkg::CSR_TARGET_MINIMUM) target = data;
         else if (index == cvs_pkg::CSR_SELECT_MODE) mode = data[0];
      endfunction

      function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
         logic [64:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[64] ? ALL_ONES : s[63:0];
      endfunction

      // Untaken entry, optionally only at or above the target, with the smallest or largest value, lower index on ties
      function int find_best(bit largest, bit need_reach);
         int best;
         best = -1;
         for (int i = 0; i < loaded; i++) begin
            if (taken[i]) continue;
            if (need_reach && amounts[i] < target) continue;
            if (best < 0 || (largest ? amounts[i] > amounts[best]
                                     : amounts[i] < amounts[best]))
               best = i;
         end
         return best;
      endfunction

      function void take(int i);
         pick_type p;
         taken[i] = 1'b1;
         p = '{1'b1, 5'(i), amounts[i], 1'b0};
         run_picks.insert(run_picks.size(), p);
      endfunction

      function void note_point(logic [63:0] amount, logic last);
         int          best;
         logic [63:0] sum;
         pick_type    p;
         // drop points that arrive with the store full
         if (loaded < cvs_pkg::MAX_POINTS) begin
            amounts[loaded] = amount;
            loaded++;
            total = sat_sum(total, amount);
         end
         if (!last) return;
         foreach (taken[i]) taken[i] = 1'b0;
         run_picks.delete();
         if (mode) begin
            best = find_best(1'b0, 1'b1);
            while (best >= 0) begin
               take(best);
               best = find_best(1'b0, 1'b1);
            end
         end else if (total >= target && loaded > 0) begin
            if (loaded == 1) begin
               take(0);
            end else begin
               best = find_best(1'b0, 1'b1);
               if (best >= 0) begin
                  take(best);
               end else begin
                  sum  = '0;
                  best = find_best(1'b1, 1'b0);
                  while (best >= 0) begin
                     take(best);
                     sum = sat_sum(sum, amounts[best]);
                     if (sum >= target) break;
                     best = find_best(1'b1, 1'b0);
                  end
               end
            end
         end
         if (run_picks.size() == 0) begin
            p = '{1'b0, 5'd0, 64'd0, 1'b0};
            run_picks.insert(run_picks.size(), p);
         end
         p = run_picks.pop_back();
         p.run_end = 1'b1;
         run_picks.insert(run_picks.size(), p);
         foreach (run_picks[i]) expected_picks.insert(expected_picks.size(), run_picks[i]);
         loaded = 0;
         total  = '0;
      endfunction

      function void check_result(logic found, logic [4:0] index, logic [63:0] amount,
                                 logic run_end);
         pick_type want;
         checked++;
         if (expected_picks.size() == 0) begin
            errors++;
            $error("result with nothing pending: index %0d, amount %0h", index, amount);
            return;
         end
         want = expected_picks.pop_front();
         if (found !== want.found) begin
            errors++;
            $error("found: expected %0d, actual %0d", want.found, found);
         end
         if (index !== want.index) begin
            errors++;
            $error("point_index: expected %0d, actual %0d", want.index, index);
         end
         if (amount !== want.amount) begin
            errors++;
            $error("chosen_amount: expected %h, actual %h", want.amount, amount);
         end
         if (run_end !== want.run_end) begin
            errors++;
            $error("run_end: expected %0d, actual %0d", want.run_end, run_end);
         end
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [63:0]                   req_point_amount = '0;
   logic                          req_final_point = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_found;
   logic [4:0]                    rsp_point_index;
   logic [63:0]                   rsp_chosen_amount;
   logic                          rsp_run_end;
   logic                          csr_wr_en = 1'b0;
   logic [cvs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]                   csr_wr_data = '0;

   selection_checker sb;
   logic [63:0]      set_amounts [$];
   int               req_gap_max = 18;
   int               rsp_gap_max = 18;
   int               points_sent = 0;
   int               runs = 0;
   int               full_runs = 0;
   int               settings = 0;

   coin_value_selector DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_point_amount  (req_point_amount),
      .req_final_point   (req_final_point),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_point_index   (rsp_point_index),
      .rsp_chosen_amount (rsp_chosen_amount),
      .rsp_run_end       (rsp_run_end),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic send_point(input logic [63:0] amount, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_point_amount <= amount;
      req_final_point  <= last;
      do @(posedge clock); while (!req_ready);
      // valid stays high here; the next call or settle() decides
      sb.note_point(amount, last);
      points_sent++;
   endtask

   task automatic run_set();
      foreach (set_amounts[i]) send_point(set_amounts[i], i == set_amounts.size() - 1);
      runs++;
      if (set_amounts.size() > cvs_pkg::MAX_POINTS) full_runs++;
   endtask

   // Drop valid, wait for every pending result, then let the run close out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(input logic [cvs_pkg::CSR_IDX_W-1:0] index,
                            input logic [63:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_register(index, data);
   endtask

   task automatic configure(input logic [63:0] target, input logic mode);
      settle();
      write_csr(cvs_pkg::CSR_TARGET_MINIMUM, target);
      write_csr(cvs_pkg::CSR_SELECT_MODE, {63'd0, mode});
      settings++;
   endtask

   function automatic logic [63:0] random_amount(logic [63:0] target, logic [63:0] prev);
      case ($urandom_range(0, 8))
         0: return {$urandom, $urandom};
         1: return target + 64'($urandom_range(0, 3));
         2: return target - 64'($urandom_range(0, 3));
         3: return target >> $urandom_range(1, 4);
         4: return '0;
         5: return ALL_ONES;
         6: return 64'($urandom_range(0, 1000));
         7: return {$urandom, $urandom} >> $urandom_range(0, 63);
         default: return prev;
      endcase
   endfunction

   initial begin : response_side
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_found, rsp_point_index, rsp_chosen_amount, rsp_run_end);
      end
   end

   initial begin : stimulus
      logic [63:0] target;
      logic [63:0] prev;
      int          len;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // unreachable target, saturation, ties and largest-first fill
      configure(ALL_ONES, 1'b0);
      set_amounts = '{ALL_ONES, ALL_ONES};
      run_set();
      set_amounts = '{64'd0};
      run_set();
      set_amounts = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1};
      run_set();

      configure(64'd150, 1'b0);
      set_amounts = '{64'd100, 64'd60, 64'd30, 64'd90};
      run_set();
      set_amounts = '{64'd200, 64'd150, 64'd300};
      run_set();
      set_amounts = '{64'd10, 64'd20};
      run_set();

      configure(64'd100, 1'b1);
      set_amounts = '{64'd100, 64'd50, 64'd200, 64'd100};
      run_set();
      set_amounts = '{64'd5};
      run_set();

      configure(64'd0, 1'b1);
      set_amounts = '{64'd0, ALL_ONES};
      run_set();

      while (points_sent < POINT_GOAL) begin
         case ($urandom_range(0, 4))
            0: target = '0;
            1: target = ALL_ONES;
            2: target = {$urandom, $urandom};
            3: target = 64'($urandom_range(0, 2000));
            default: target = {$urandom, $urandom} >> $urandom_range(1, 63);
         endcase
         configure(target, 1'($urandom_range(0, 1)));
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
         repeat ($urandom_range(1, 5)) begin
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(32, 35)
                                                : $urandom_range(1, 8);
            prev = {$urandom, $urandom};
            set_amounts.delete();
            repeat (len) begin
               prev = random_amount(target, prev);
               set_amounts.insert(set_amounts.size(), prev);
            end
            run_set();
         end
      end
      settle();

      $display("Covered %0d points in %0d selection runs (%0d overfilled the store).",
               points_sent, runs, full_runs);
      $display("Checked %0d results under %0d register settings in both modes.",
               sb.checked, settings);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
